// ===== src/tfl_pkg.sv =====
// ----------------------------------------------------------------------------
// tfl_pkg: shared types and constants for the two-region page free list
// Holds status codes, configuration register indexes and the fixed widths.
// ----------------------------------------------------------------------------
package tfl_pkg;

  localparam int ADDR_W    = 64;
  localparam int BASE_W    = 52;
  localparam int KP_W      = 13;
  localparam int FC_W      = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 52;

  localparam logic [KP_W-1:0] KP_RST = 13'd1024;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_BASE_PAGE  = 1'b0;
  localparam cfg_idx_t CFG_KERN_SPLIT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_PAGE = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

endpackage

// ===== src/tfl_req_if.sv =====
// ----------------------------------------------------------------------------
// tfl_req_if: request channel of the page free list
// Valid/ready handshake with the allocate/free request payload.
// ----------------------------------------------------------------------------
interface tfl_req_if;
  import tfl_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic              kern_sel;
  logic [ADDR_W-1:0] page_addr;

  modport source (output valid, output req_type, output kern_sel, output page_addr,
                  input ready);
  modport sink   (input valid, input req_type, input kern_sel, input page_addr,
                  output ready);
endinterface

// ===== src/tfl_res_if.sv =====
// ----------------------------------------------------------------------------
// tfl_res_if: result channel of the page free list
// Valid/ready handshake carrying address, status and remaining free count.
// ----------------------------------------------------------------------------
interface tfl_res_if;
  import tfl_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] alloc_addr;
  logic [1:0]        status;
  logic [FC_W-1:0]   free_count;

  modport source (output valid, output alloc_addr, output status, output free_count,
                  input ready);
  modport sink   (input valid, input alloc_addr, input status, input free_count,
                  output ready);
endinterface

// ===== src/tfl_ram.sv =====
// ----------------------------------------------------------------------------
// tfl_ram: generic single-clock RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tfl_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/two_region_page_free_list.sv =====
// ----------------------------------------------------------------------------
// two_region_page_free_list: kernel/user page allocator
// Two LIFO free lists sharing one recycled-page memory.
// ----------------------------------------------------------------------------
// The block serves allocate and free requests for PAGE_COUNT pages that start
// at page base_page; the pages below the kernel split form the kernel region,
// the rest the user region. Each region hands out never-used pages from a
// watermark, highest first, and recycles freed pages through a stack in a
// shared memory (kernel stack grows up from entry 0, user stack down from the
// last entry). A request is decided in the cycle it is accepted, the recycled
// memory is read or written at that edge, and the result goes through the
// decision and output registers. One request per cycle is sustained while the
// output is not stalled: each request makes at most one access to the recycled
// memory, and a pop always reads an entry whose push completed at an earlier
// edge, so no forwarding is needed. Writing either configuration register
// reinitializes both regions; the memory needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module two_region_page_free_list #(
  parameter int PAGE_COUNT = 4096,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  tfl_pkg::cfg_idx_t         cfg_index,
  input  logic [tfl_pkg::CFG_W-1:0] cfg_data,
  tfl_req_if.sink                   in_req,
  tfl_res_if.source                 out_res
);
  import tfl_pkg::*;

  localparam int CNT_W   = $clog2(PAGE_COUNT + 1);
  localparam int OFF_W   = $clog2(PAGE_COUNT);
  localparam int CMP_W   = (CNT_W > KP_W) ? CNT_W : KP_W;
  localparam int KSZ_RST = (PAGE_COUNT < 1024) ? PAGE_COUNT : 1024;

  localparam logic [CNT_W-1:0] TOTAL_C  = CNT_W'(PAGE_COUNT);
  localparam logic [CNT_W-1:0] TOTAL_M1 = CNT_W'(PAGE_COUNT - 1);

  // configuration and region state
  logic [BASE_W-1:0] base_r;
  logic [KP_W-1:0]   kp_r;
  logic [CNT_W-1:0]  ksz_r, usize_r;
  logic [CNT_W-1:0]  kf_r, uf_r, krc_r, urc_r;

  // decision stage
  logic              s1_valid_r;
  logic              s1_alloc_ok_r;
  logic              s1_from_ram_r;
  logic [OFF_W-1:0]  s1_off_r;
  status_t           s1_status_r;
  logic [CNT_W-1:0]  s1_cnt_r;

  // output stage
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  status_t           out_status_r;
  logic [FC_W-1:0]   out_fc_r;

  logic              accept, s1_adv;
  logic              kern;
  logic [CNT_W-1:0]  fresh, rc, lo, size, fresh_nxt, rc_nxt, cnt;
  logic [ADDR_W-1:0] pn, off, lo64, hi64;
  status_t           status;
  logic              alloc_ok, from_ram;
  logic [OFF_W-1:0]  fresh_off;
  logic              ram_we, ram_re;
  logic [OFF_W-1:0]  ram_waddr, ram_raddr, ram_wdata, ram_rdata;
  logic [KP_W-1:0]   cfg_kp;
  logic [CNT_W-1:0]  cfg_ksz;
  logic [ADDR_W-1:0] off64, addr_nxt;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_req.ready = !s1_valid_r || s1_adv;
  assign accept       = in_req.valid && in_req.ready;

  // decide the request against the current region state
  always_comb begin
    kern      = in_req.kern_sel;
    fresh     = kern ? kf_r : uf_r;
    rc        = kern ? krc_r : urc_r;
    lo        = kern ? '0 : ksz_r;
    size      = kern ? ksz_r : usize_r;
    pn        = in_req.page_addr >> PAGE_SHIFT;
    off       = pn - ADDR_W'(base_r);
    lo64      = ADDR_W'(lo);
    hi64      = ADDR_W'(lo + size);
    fresh_nxt = fresh;
    rc_nxt    = rc;
    status    = ST_OK;
    alloc_ok  = 1'b0;
    from_ram  = 1'b0;
    fresh_off = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = kern ? OFF_W'(rc) : OFF_W'(TOTAL_M1 - rc);
    ram_raddr = kern ? OFF_W'(rc - 1'b1) : OFF_W'(TOTAL_C - rc);
    ram_wdata = off[OFF_W-1:0];
    if (in_req.req_type == REQ_ALLOC) begin
      if (rc != '0) begin
        ram_re   = accept;
        alloc_ok = 1'b1;
        from_ram = 1'b1;
        rc_nxt   = rc - 1'b1;
      end else if (fresh != '0) begin
        fresh_nxt = fresh - 1'b1;
        fresh_off = OFF_W'(lo + fresh - 1'b1);
        alloc_ok  = 1'b1;
      end else begin
        status = ST_EMPTY;
      end
    end else begin
      if (in_req.page_addr[PAGE_SHIFT-1:0] != '0 || pn < ADDR_W'(base_r) ||
          off < lo64 || off >= hi64) begin
        status = ST_BAD_PAGE;
      end else if (fresh + rc >= size) begin
        status = ST_FULL;
      end else begin
        ram_we = accept;
        rc_nxt = rc + 1'b1;
      end
    end
    cnt = fresh_nxt + rc_nxt;
  end

  // region size after a configuration write, saturated to the page count
  always_comb begin
    cfg_kp  = (cfg_index == CFG_KERN_SPLIT) ? cfg_data[KP_W-1:0] : kp_r;
    cfg_ksz = (CMP_W'(cfg_kp) > CMP_W'(PAGE_COUNT)) ? TOTAL_C : CNT_W'(cfg_kp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      kp_r    <= KP_RST;
      ksz_r   <= CNT_W'(KSZ_RST);
      usize_r <= CNT_W'(PAGE_COUNT - KSZ_RST);
      kf_r    <= CNT_W'(KSZ_RST);
      uf_r    <= CNT_W'(PAGE_COUNT - KSZ_RST);
      krc_r   <= '0;
      urc_r   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BASE_PAGE) begin
        base_r <= cfg_data[BASE_W-1:0];
      end
      kp_r    <= cfg_kp;
      ksz_r   <= cfg_ksz;
      usize_r <= TOTAL_C - cfg_ksz;
      kf_r    <= cfg_ksz;
      uf_r    <= TOTAL_C - cfg_ksz;
      krc_r   <= '0;
      urc_r   <= '0;
    end else if (accept) begin
      if (kern) begin
        kf_r  <= fresh_nxt;
        krc_r <= rc_nxt;
      end else begin
        uf_r  <= fresh_nxt;
        urc_r <= rc_nxt;
      end
    end
  end

  tfl_ram #(
    .WIDTH (OFF_W),
    .DEPTH (PAGE_COUNT)
  ) u_recycled (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_alloc_ok_r <= alloc_ok;
      s1_from_ram_r <= from_ram;
      s1_off_r      <= fresh_off;
      s1_status_r   <= status;
      s1_cnt_r      <= cnt;
    end
  end

  // form the byte address once the recycled entry is back
  always_comb begin
    off64    = s1_from_ram_r ? ADDR_W'(ram_rdata) : ADDR_W'(s1_off_r);
    addr_nxt = s1_alloc_ok_r ? ((ADDR_W'(base_r) + off64) << PAGE_SHIFT) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_addr_r   <= addr_nxt;
      out_status_r <= s1_status_r;
      out_fc_r     <= FC_W'(s1_cnt_r);
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.alloc_addr = out_addr_r;
  assign out_res.status     = out_status_r;
  assign out_res.free_count = out_fc_r;

  a_kern_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W+1)'(kf_r) + (CNT_W+1)'(krc_r) <= (CNT_W+1)'(ksz_r))
    else $error("kernel region holds more pages than its size");

  a_user_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W+1)'(uf_r) + (CNT_W+1)'(urc_r) <= (CNT_W+1)'(usize_r))
    else $error("user region holds more pages than its size");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W+1)'(krc_r) + (CNT_W+1)'(urc_r) <= (CNT_W+1)'(TOTAL_C))
    else $error("recycled stacks overlap in memory");

  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("push and pop issued in the same cycle");

  a_pop_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> !$past(ram_re))
    else $error("recycled read issued while the decision stage stalls");

endmodule
